// File: rtl/core/deadline_ordered_timeout_queue_assert.svh
// assertion macros used by the timeout queue sequencer
// no other dependencies
`ifndef DEADLINE_ORDERED_TIMEOUT_QUEUE_ASSERT_SVH
`define DEADLINE_ORDERED_TIMEOUT_QUEUE_ASSERT_SVH
// implication checked on every rising edge outside reset
`define DOTQ_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("implication check failed");
// next-cycle implication
`define DOTQ_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("check failed");
`endif

// File: rtl/core/dotq_pkg.sv
// package for the timeout queue: sizes, codes and payload structs
// no dependencies
`timescale 1ns / 1ps
package dotq_pkg;
	localparam int Depth = 16;
	localparam int TimeWidth = 48;
	localparam int AddrWidth = $clog2(Depth);
	localparam int CntWidth = $clog2(Depth + 1);

	localparam logic [1:0] ACT_INSERT = 2'd0;
	localparam logic [1:0] ACT_REMOVE = 2'd1;
	localparam logic [1:0] ACT_TICK = 2'd2;

	localparam logic [2:0] ST_INSERTED = 3'd0;
	localparam logic [2:0] ST_FULL = 3'd1;
	localparam logic [2:0] ST_REMOVED = 3'd2;
	localparam logic [2:0] ST_FIRED = 3'd3;
	localparam logic [2:0] ST_IDLE = 3'd4;

	typedef struct packed {
		logic [1:0] action;
		logic [TimeWidth-1:0] deadline;
		logic [7:0] source_id;
		logic [15:0] data_key;
		logic [15:0] event_tag;
		logic [TimeWidth-1:0] now_time;
	} in_item_t;

	typedef struct packed {
		logic [2:0] status;
		logic [4:0] removed_count;
		logic [7:0] fired_source;
		logic [15:0] fired_data_key;
		logic [15:0] fired_event_tag;
		logic [4:0] occupancy;
	} out_item_t;

	typedef struct packed {
		logic [TimeWidth-1:0] deadline;
		logic [7:0] source;
		logic [15:0] key;
		logic [15:0] tag;
	} entry_t;

	// memory port bundle from sequencer to store
	typedef struct packed {
		logic re;
		logic [AddrWidth-1:0] raddr;
		logic we;
		logic [AddrWidth-1:0] waddr;
		entry_t wdata;
	} mem_req_t;
endpackage

// File: rtl/core/dotq_store.sv
// entry store: one write port and one read port with registered read data
// depends on dotq_pkg
`timescale 1ns / 1ps
module dotq_store import dotq_pkg::*; (
	input logic clk,
	input mem_req_t req,
	output entry_t rdata
);
	entry_t mem [Depth];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		if (req.re) begin
			rdata <= mem[req.raddr];
		end
	end
endmodule

// File: rtl/core/dotq_seq.sv
// sequencer: walks the entry store for insert, remove and tick
// depends on dotq_pkg and the assertion header
`timescale 1ns / 1ps
`include "deadline_ordered_timeout_queue_assert.svh"
module dotq_seq import dotq_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input in_item_t in_item,
	output logic out_valid,
	input logic out_ready,
	output out_item_t out_item,
	output mem_req_t req,
	input entry_t rdata
);
	typedef enum logic [1:0] {S_IDLE, S_WALK, S_DONE} state_t;

	state_t state_q;
	in_item_t cmd_q;
	logic [CntWidth-1:0] count_q, rd_q, keep_q, removed_q;
	logic pend_q, found_q;
	entry_t carry_q, head_q;

	// read address counter reaches count: last read issued
	logic more_rd;
	logic tick_stop;
	logic [CntWidth-1:0] n_count;
	logic [2:0] n_status;

	assign more_rd = rd_q < count_q;
	assign in_ready = (state_q == S_IDLE) && (!out_valid || out_ready);
	// stop after the head if it is not due
	assign tick_stop = pend_q && cmd_q.action == ACT_TICK && keep_q == '0
		&& rdata.deadline > cmd_q.now_time;

	always_comb begin
		req = '0;
		req.raddr = rd_q[AddrWidth-1:0];
		req.re = (state_q == S_WALK) && more_rd;
		if (state_q == S_WALK && pend_q) begin
			unique case (cmd_q.action)
				ACT_INSERT: begin
					// slide entries up by one after the slot is found
					req.waddr = keep_q[AddrWidth-1:0];
					if (found_q) begin
						req.we = 1'b1;
						req.wdata = carry_q;
					end else if (rdata.deadline > cmd_q.deadline) begin
						req.we = 1'b1;
						req.wdata = '{cmd_q.deadline, cmd_q.source_id, cmd_q.data_key,
							cmd_q.event_tag};
					end
				end
				ACT_REMOVE: begin
					req.waddr = keep_q[AddrWidth-1:0];
					req.we = !(rdata.source == cmd_q.source_id && rdata.key == cmd_q.data_key);
					req.wdata = rdata;
				end
				ACT_TICK: begin
					// each entry behind the head moves down by one
					req.waddr = AddrWidth'(keep_q - 1'b1);
					req.we = keep_q != '0;
					req.wdata = rdata;
				end
				default: ;
			endcase
		end else if (state_q == S_DONE && cmd_q.action == ACT_INSERT) begin
			req.waddr = keep_q[AddrWidth-1:0];
			req.we = count_q < CntWidth'(Depth);
			req.wdata = found_q ? carry_q : '{cmd_q.deadline, cmd_q.source_id,
				cmd_q.data_key, cmd_q.event_tag};
		end
	end

	always_comb begin
		n_count = count_q;
		n_status = ST_IDLE;
		case (cmd_q.action)
			ACT_INSERT: begin
				n_status = (count_q < CntWidth'(Depth)) ? ST_INSERTED : ST_FULL;
				if (count_q < CntWidth'(Depth)) n_count = count_q + 1'b1;
			end
			ACT_REMOVE: begin
				n_status = ST_REMOVED;
				n_count = count_q - removed_q;
			end
			ACT_TICK: begin
				if (count_q != '0 && head_q.deadline <= cmd_q.now_time) begin
					n_status = ST_FIRED;
					n_count = count_q - 1'b1;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			out_valid <= 1'b0;
			pend_q <= 1'b0;
		end else begin
			if (out_valid && out_ready) out_valid <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (in_valid && in_ready) begin
						cmd_q <= in_item;
						rd_q <= '0;
						keep_q <= '0;
						removed_q <= '0;
						found_q <= 1'b0;
						pend_q <= 1'b0;
						// full inserts and unused codes skip the walk
						if (in_item.action == ACT_INSERT && count_q >= CntWidth'(Depth))
							state_q <= S_DONE;
						else if (in_item.action == ACT_TICK || in_item.action == ACT_INSERT
							|| in_item.action == ACT_REMOVE)
							state_q <= S_WALK;
						else
							state_q <= S_DONE;
					end
				end
				S_WALK: begin
					if (more_rd) rd_q <= rd_q + 1'b1;
					pend_q <= more_rd && !tick_stop;
					if (pend_q) begin
						unique case (cmd_q.action)
							ACT_INSERT: begin
								if (found_q) begin
									carry_q <= rdata;
								end else if (rdata.deadline > cmd_q.deadline) begin
									found_q <= 1'b1;
									carry_q <= rdata;
								end
								keep_q <= keep_q + 1'b1;
							end
							ACT_REMOVE: begin
								if (rdata.source == cmd_q.source_id && rdata.key == cmd_q.data_key)
									removed_q <= removed_q + 1'b1;
								else
									keep_q <= keep_q + 1'b1;
							end
							ACT_TICK: begin
								if (keep_q == '0) head_q <= rdata;
								keep_q <= keep_q + 1'b1;
							end
							default: ;
						endcase
					end
					if (tick_stop || (!more_rd && !pend_q)) state_q <= S_DONE;
				end
				S_DONE: begin
					count_q <= n_count;
					out_item <= '{n_status, 5'(removed_q),
						(n_status == ST_FIRED) ? head_q.source : 8'd0,
						(n_status == ST_FIRED) ? head_q.key : 16'd0,
						(n_status == ST_FIRED) ? head_q.tag : 16'd0,
						5'(n_count)};
					out_valid <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`DOTQ_ASSERT_IMP(a_count_range, 1'b1, count_q <= CntWidth'(Depth))
	`DOTQ_ASSERT_IMP(a_no_accept_busy, state_q != S_IDLE, !in_ready)
	`DOTQ_ASSERT_IMP(a_keep_bound, state_q == S_WALK, keep_q <= rd_q)
	`DOTQ_ASSERT_NXT(a_done_result, state_q == S_DONE, out_valid)
endmodule

// File: rtl/core/deadline_ordered_timeout_queue.sv
// each item is taken, walked through the single-read-port entry store and answered
// with one result; a full insert or an unused code skips the walk, and a tick whose
// head is not due stops after reading the head
// one item at a time: a new item is taken only after the last one is done and its
// result is accepted or being accepted
// reset: arst_n clears the entry count and the result flag; entries stay undefined
`timescale 1ns / 1ps
module deadline_ordered_timeout_queue import dotq_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input in_item_t in_item,
	output logic out_valid,
	input logic out_ready,
	output out_item_t out_item
);
	mem_req_t req;
	entry_t rdata;

	dotq_seq u_seq (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.in_item(in_item), .out_valid(out_valid), .out_ready(out_ready),
		.out_item(out_item), .req(req), .rdata(rdata)
	);

	dotq_store u_store (.clk(clk), .req(req), .rdata(rdata));
endmodule
